FILE: rtl/dbnm_pkg.sv
// ----------------------------------------------------------------------------
// dbnm_pkg: shared definitions for the double-buffered neighbor mailbox
// Command codes and the fixed field widths of the transaction ports.
// ----------------------------------------------------------------------------
package dbnm_pkg;

  // Fixed port field widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned NbrW     = 4;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ActiveW  = 5;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PHASE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

endpackage

FILE: rtl/double_buffered_neighbor_mailbox.sv
// Add, change phase and clear pass through ST_EXEC and ST_FINISH before the result is registered.
// Pop stays in ST_EXEC while the scan pointer walks past empty queues, one queue per cycle;
// the single per-cycle queue lookup and the payload RAM read port set that pace.
// A new transaction is taken only in ST_IDLE; input stall is high until the
// result is registered, and a held result register also holds the sequencer.
// Reset: asynchronous, clears all queue counters, banks, scan pointer and config.
// ----------------------------------------------------------------------------
// double_buffered_neighbor_mailbox
// Two banks of per-neighbor FIFOs; adds go to the write bank, pops scan the
// read bank from a persistent pointer, change phase swaps the banks and resets the pointer.
// ----------------------------------------------------------------------------
module double_buffered_neighbor_mailbox
  import dbnm_pkg::*;
#(
  parameter int unsigned MAX_NEIGHBORS = 16,
  parameter int unsigned QUEUE_DEPTH   = 8,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [ActiveW-1:0] cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [NbrW-1:0]    neighbor_i,
  input  logic [WordW-1:0]   payload_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [NbrW-1:0]    from_neighbor_o,
  output logic [WordW-1:0]   message_o,
  output logic               read_bank_empty_o,
  output logic               dropped_o
);

  localparam int unsigned NbW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CntW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned FcW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PosW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned StoreW = (PAYLOAD_WIDTH < WordW) ? PAYLOAD_WIDTH : WordW;
  localparam int unsigned AddrW  = 1 + NbW + PosW;
  localparam int unsigned MemD   = 2 ** AddrW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration and control registers
  logic [ActiveW-1:0] active_q;
  logic               rb_q;
  logic [CntW-1:0]    scan_q;

  // per bank, per neighbor queue bookkeeping
  logic [FcW-1:0]          fc_q [2][MAX_NEIGHBORS];
  logic [FcW-1:0]          rp_q [2][MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] ne_q [2];

  // accepted transaction
  cmd_e              cmd_q;
  logic [NbrW-1:0]   nbr_q;
  logic [StoreW-1:0] pay_q;

  // work results
  logic              found_q;
  logic [NbW-1:0]    from_q;
  logic              drop_q;

  // output register
  logic              out_valid_q;
  logic              out_found_q;
  logic [NbrW-1:0]   out_from_q;
  logic [WordW-1:0]  out_msg_q;
  logic              out_empty_q;
  logic              out_drop_q;

  // payload RAM
  logic [StoreW-1:0] mem_q [MemD];
  logic [StoreW-1:0] rd_data_q;
  logic              mem_we;
  logic              mem_re;
  logic [AddrW-1:0]  mem_addr;

  // lookup unit signals
  logic [CntW-1:0]          lim;
  logic [MAX_NEIGHBORS-1:0] act_mask;
  logic                     sel_bank;
  logic [NbW-1:0]           sel_idx;
  logic [FcW-1:0]           fc_sel;
  logic [FcW-1:0]           rp_sel;
  logic                     ne_sel;
  logic [FcW-1:0]           fc_base;
  logic [FcW-1:0]           rp_next;
  logic                     add_ok;
  logic                     add_in_range;
  logic                     scan_done;
  logic                     in_accept;
  logic                     out_free;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Active count, capped at the number of queues
  always_comb begin
    if (32'(active_q) > MAX_NEIGHBORS) begin
      lim = CntW'(MAX_NEIGHBORS);
    end else begin
      lim = CntW'(active_q);
    end
  end

  for (genvar n = 0; n < MAX_NEIGHBORS; n++) begin : g_act
    assign act_mask[n] = (32'(n) < 32'(lim));
  end

  // Shared queue lookup: adds look at the write bank, pops at the scan slot
  always_comb begin
    if (cmd_q == CMD_ADD) begin
      sel_bank = ~rb_q;
      sel_idx  = NbW'(nbr_q);
    end else begin
      sel_bank = rb_q;
      sel_idx  = NbW'(scan_q);
    end
    fc_sel       = fc_q[sel_bank][sel_idx];
    rp_sel       = rp_q[sel_bank][sel_idx];
    ne_sel       = ne_q[sel_bank][sel_idx];
    fc_base      = ne_sel ? fc_sel : '0;
    rp_next      = rp_sel + FcW'(1);
    add_in_range = (32'(nbr_q) < 32'(lim));
    add_ok       = add_in_range && (fc_base < FcW'(QUEUE_DEPTH));
    scan_done    = (scan_q >= lim);
  end

  // RAM port control
  always_comb begin
    mem_we   = (state_q == ST_EXEC) && (cmd_q == CMD_ADD) && add_ok;
    mem_re   = (state_q == ST_EXEC) && (cmd_q == CMD_POP) && !scan_done && ne_sel;
    mem_addr = mem_we ? {sel_bank, sel_idx, fc_base[PosW-1:0]}
                      : {sel_bank, sel_idx, rp_sel[PosW-1:0]};
  end

  // Payload RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= pay_q;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  // Transaction payload capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      nbr_q <= neighbor_i;
      pay_q <= StoreW'(payload_i);
    end
  end

  // Sequencer, bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      rb_q        <= 1'b0;
      scan_q      <= '0;
      cmd_q       <= CMD_ADD;
      found_q     <= 1'b0;
      from_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_from_q  <= '0;
      out_msg_q   <= '0;
      out_empty_q <= 1'b0;
      out_drop_q  <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        ne_q[b] <= '0;
        for (int n = 0; n < MAX_NEIGHBORS; n++) begin
          fc_q[b][n] <= '0;
          rp_q[b][n] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
      // result taken; in ST_FINISH the reload below decides the flag
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= cmd_e'(command_i);
            found_q <= 1'b0;
            from_q  <= '0;
            drop_q  <= 1'b0;
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          unique case (cmd_q)
            CMD_ADD: begin
              if (add_ok) begin
                fc_q[sel_bank][sel_idx] <= fc_base + FcW'(1);
                rp_q[sel_bank][sel_idx] <= ne_sel ? rp_sel : '0;
                ne_q[sel_bank][sel_idx] <= 1'b1;
              end
              drop_q  <= !add_ok;
              state_q <= ST_FINISH;
            end
            CMD_POP: begin
              // one queue slot per cycle until a message or the end
              if (scan_done) begin
                state_q <= ST_FINISH;
              end else if (!ne_sel) begin
                scan_q <= scan_q + CntW'(1);
              end else begin
                rp_q[sel_bank][sel_idx] <= rp_next;
                ne_q[sel_bank][sel_idx] <= (rp_next != fc_sel);
                found_q <= 1'b1;
                from_q  <= sel_idx;
                state_q <= ST_FINISH;
              end
            end
            CMD_PHASE: begin
              rb_q    <= ~rb_q;
              scan_q  <= '0;
              state_q <= ST_FINISH;
            end
            CMD_CLEAR: begin
              for (int b = 0; b < 2; b++) begin
                ne_q[b] <= '0;
                for (int n = 0; n < MAX_NEIGHBORS; n++) begin
                  fc_q[b][n] <= '0;
                  rp_q[b][n] <= '0;
                end
              end
              state_q <= ST_FINISH;
            end
            default: begin
              state_q <= ST_FINISH;
            end
          endcase
        end

        ST_FINISH: begin
          // load the result once the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_found_q <= found_q;
            out_from_q  <= NbrW'(from_q);
            out_msg_q   <= found_q ? WordW'(rd_data_q) : '0;
            out_empty_q <= ~|(ne_q[rb_q] & act_mask);
            out_drop_q  <= drop_q;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign found_o           = out_found_q;
  assign from_neighbor_o   = out_from_q;
  assign message_o         = out_msg_q;
  assign read_bank_empty_o = out_empty_q;
  assign dropped_o         = out_drop_q;

`ifndef NO_ASSERTIONS
  // Non-empty flag agrees with the counters of the queue under lookup
  a_ne_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && (((cmd_q == CMD_ADD) && add_in_range) ||
                             ((cmd_q == CMD_POP) && !scan_done))
    |-> (ne_sel == (fc_sel != rp_sel)) && (rp_sel <= fc_sel))
    else $error("queue non-empty flag out of step with counters");

  // An accepted transaction always starts the sequencer
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_EXEC))
    else $error("accepted transaction did not start");

  // A result never both returns a message and reports a drop
  a_found_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && dropped_o))
    else $error("found and dropped both set");

  // Without a message the message fields are zero
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> ((message_o == '0) && (from_neighbor_o == '0)))
    else $error("message fields nonzero without a message");
`endif

endmodule
